// File: src/snm_pkg.sv
// Shared widths, codes and arithmetic helpers of the Sobel normal-map block.
package snm_pkg;

	localparam int HGT_W  = 16;   // stored height, unsigned Q1.15
	localparam int D_W    = 20;   // signed gradient sum
	localparam int MAG_W  = 18;   // gradient magnitude
	localparam int SQ_W   = 38;   // dx^2 + dy^2 + dz^2
	localparam int RAD_W  = 48;   // square-root radicand
	localparam int ROOT_W = 24;   // square root
	localparam int NUM_W  = 33;   // dividend
	localparam int DEN_W  = 19;   // divisor
	localparam int SUMC_W = 18;   // red^2 + green^2 + blue^2
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 11;

	// Height divide by 255 as a reciprocal multiply: ceil(2^32/255), exact for roots below 2^24.
	localparam int HGT_RCP_W  = 25;
	localparam int HGT_PROD_W = ROOT_W + HGT_RCP_W;
	localparam int HGT_RCP_SH = 32;
	localparam logic [HGT_RCP_W-1:0] HGT_RECIP = 25'd16843010;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [MAG_W-1:0] DZ_Q15     = 18'd10813;

	// neighbour read order
	localparam logic [2:0] NB_TL = 3'd0;
	localparam logic [2:0] NB_T  = 3'd1;
	localparam logic [2:0] NB_TR = 3'd2;
	localparam logic [2:0] NB_R  = 3'd3;
	localparam logic [2:0] NB_BR = 3'd4;
	localparam logic [2:0] NB_B  = 3'd5;
	localparam logic [2:0] NB_BL = 3'd6;
	localparam logic [2:0] NB_L  = 3'd7;

	function automatic logic signed [2:0] weight_x(input logic [2:0] k);
		case (k)
			NB_TL:   weight_x = -3'sd1;
			NB_TR:   weight_x = 3'sd1;
			NB_R:    weight_x = 3'sd2;
			NB_BR:   weight_x = 3'sd1;
			NB_BL:   weight_x = -3'sd1;
			NB_L:    weight_x = -3'sd2;
			default: weight_x = 3'sd0;
		endcase
	endfunction

	function automatic logic signed [2:0] weight_y(input logic [2:0] k);
		case (k)
			NB_TL:   weight_y = -3'sd1;
			NB_T:    weight_y = -3'sd2;
			NB_TR:   weight_y = -3'sd1;
			NB_BR:   weight_y = 3'sd1;
			NB_B:    weight_y = 3'sd2;
			NB_BL:   weight_y = 3'sd1;
			default: weight_y = 3'sd0;
		endcase
	endfunction

	// Height times a weight in {-2..2}, built from shift and negate.
	function automatic logic signed [D_W-1:0] scale(input logic [HGT_W-1:0] h,
			input logic signed [2:0] w);
		logic signed [D_W-1:0] e;
		e = $signed({{(D_W-HGT_W){1'b0}}, h});
		case (w)
			3'sd1:   scale = e;
			3'sd2:   scale = e <<< 1;
			-3'sd1:  scale = -e;
			-3'sd2:  scale = -(e <<< 1);
			default: scale = '0;
		endcase
	endfunction

	// Saturate quotient, apply sign, map [-1,1] onto a byte.
	function automatic logic [7:0] to_byte(input logic neg, input logic [NUM_W-1:0] q);
		logic [16:0] qs;
		logic [16:0] u;
		logic [24:0] p;
		qs = (q > NUM_W'(32768)) ? 17'd32768 : q[16:0];
		u  = neg ? (17'd32768 - qs) : (17'd32768 + qs);
		p  = 25'(u) * 25'd255;
		to_byte = p[23:16];
	endfunction

endpackage

// File: src/snm_ram.sv
// Generic single-port synchronous RAM with registered read.
module snm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: src/snm_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module snm_sqrt
	import snm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  rad,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;

	assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: src/snm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module snm_div
	import snm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: src/sobel_normal_map.sv
// Top level of the Sobel normal-map block: height store, neighbour reads, normalize.
//
// Write requests (tuser 0) turn an RGB pixel into a Q1.15 height,
// sqrt(r^2+g^2+b^2)/255, and store it at (col,row) in a single-port RAM of
// MAX_WIDTH*MAX_HEIGHT entries; writes outside the store are dropped and give
// no result. Query requests (tuser 1) read the eight wrapped neighbours of
// (col,row) one per cycle, form the Sobel sums dx and dy, normalize
// (dx,dy,0.33) and return the three components as bytes on the master side.
// One request is worked on at a time, and the bit-serial units are shared:
// the square root (one bit per cycle for 24 bits) serves writes and queries,
// the divide by 255 of a write is a combinational reciprocal multiply, and
// the divider (33 quotient bits) is used three times per query, with the
// eight reads of the single RAM port in front. A finished query waits for a
// free output register. A finished result waits in the output register while
// the next request is taken. Query only entries already written; the store
// has no reset and no clearing pass. Configuration writes (index 0 width,
// index 1 height, 0 acting as 1 and values above the maximum clamped) are
// always accepted and belong between requests.
module sobel_normal_map
	import snm_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [47:0]          s_tdata,   // col[9:0], row[19:10], red[27:20],
	                                        // green[35:28], blue[43:36], zero pad
	input  logic                 s_tuser,   // func: 0 write height, 1 query
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // normal_x[7:0], normal_y[15:8], normal_z[23:16]
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int XW    = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
	localparam int YW    = ($clog2(MAX_HEIGHT + 1) > 11) ? $clog2(MAX_HEIGHT + 1) : 11;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int RST_W = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
	localparam int RST_H = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_HSQ   = 4'd1;
	localparam logic [3:0] ST_HSQRT = 4'd2;
	localparam logic [3:0] ST_HWR   = 4'd4;
	localparam logic [3:0] ST_NB    = 4'd5;
	localparam logic [3:0] ST_RD    = 4'd6;
	localparam logic [3:0] ST_ACC   = 4'd7;
	localparam logic [3:0] ST_SQX   = 4'd8;
	localparam logic [3:0] ST_SQY   = 4'd9;
	localparam logic [3:0] ST_LSQRT = 4'd10;
	localparam logic [3:0] ST_CST   = 4'd11;
	localparam logic [3:0] ST_CDIV  = 4'd12;
	localparam logic [3:0] ST_OUT   = 4'd13;

	logic [3:0]        state_q;
	logic [XW-1:0]     wsz_q;
	logic [YW-1:0]     hsz_q;
	logic [9:0]        col_q, row_q;
	logic [7:0]        red_q, grn_q, blu_q;
	logic              func_q;
	logic [XW-1:0]     xm_q, x0_q, xp_q;
	logic [YW-1:0]     ym_q, y0_q, yp_q;
	logic [2:0]        rk_q;
	logic              rd_vld_s1;
	logic [2:0]        rd_k_s1;
	logic signed [D_W-1:0] dx_q, dy_q;
	logic [SQ_W-1:0]   sum_q;
	logic [ROOT_W-1:0] len_q;
	logic [HGT_W-1:0]  h_q;
	logic [AW-1:0]     wr_addr_q;
	logic              wr_ok_q;
	logic [1:0]        ci_q;
	logic [7:0]        bx_q, by_q, bz_q;
	logic              m_tvalid_q;
	logic [23:0]       m_tdata_q;

	logic              in_acc;
	logic              out_load;
	logic [CFG_DAT_W-1:0] cfg_min1;
	logic [XW-1:0]     xc, x_rd;
	logic [YW-1:0]     yc, y_rd;
	logic [AW-1:0]     rd_addr, ram_addr;
	logic              ram_we;
	logic [HGT_W-1:0]  ram_rdata;
	logic [SUMC_W-1:0] rgb_sq;
	logic [D_W-1:0]    dx_abs, dy_abs;
	logic [MAG_W-1:0]  dxm, dym;
	logic [SQ_W-1:0]   dx_sq, dy_sq;
	logic              sqrt_start, sqrt_done;
	logic [RAD_W-1:0]  sqrt_rad;
	logic [ROOT_W-1:0] sqrt_root;
	logic [HGT_PROD_W-1:0] h_prod;
	logic              div_start, div_done;
	logic [NUM_W-1:0]  div_num, div_quo;
	logic [DEN_W-1:0]  div_den;
	logic [MAG_W-1:0]  cmag;
	logic              cneg;
	logic [7:0]        cbyte;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign cfg_min1  = (cfg_data == '0) ? CFG_DAT_W'(1) : cfg_data;

	// Clamp the size registers on write: 0 acts as 1, above the maximum acts as it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsz_q <= XW'(RST_W);
			hsz_q <= YW'(RST_H);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_WIDTH) begin
				wsz_q <= (XW'(cfg_min1) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(cfg_min1);
			end else if (cfg_index == CFG_HEIGHT) begin
				hsz_q <= (YW'(cfg_min1) > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(cfg_min1);
			end
		end
	end

	// Widen the coordinates for the wrap: below zero goes to size-1, at or past the size goes to 0.
	assign xc = XW'(col_q);
	assign yc = YW'(row_q);

	// Neighbour of the current read slot.
	always_comb begin
		case (rk_q)
			NB_TL:   begin x_rd = xm_q; y_rd = ym_q; end
			NB_T:    begin x_rd = xm_q; y_rd = y0_q; end
			NB_TR:   begin x_rd = xm_q; y_rd = yp_q; end
			NB_R:    begin x_rd = x0_q; y_rd = yp_q; end
			NB_BR:   begin x_rd = xp_q; y_rd = yp_q; end
			NB_B:    begin x_rd = xp_q; y_rd = y0_q; end
			NB_BL:   begin x_rd = xp_q; y_rd = ym_q; end
			default: begin x_rd = x0_q; y_rd = ym_q; end
		endcase
	end

	assign rd_addr  = AW'(y_rd) * AW'(MAX_WIDTH) + AW'(x_rd);
	assign ram_we   = (state_q == ST_HWR) && wr_ok_q;
	assign ram_addr = (state_q == ST_HWR) ? wr_addr_q : rd_addr;

	snm_ram #(
		.WIDTH (HGT_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (h_q),
		.rdata (ram_rdata)
	);

	assign rgb_sq = SUMC_W'(16'(red_q) * 16'(red_q)) + SUMC_W'(16'(grn_q) * 16'(grn_q))
		+ SUMC_W'(16'(blu_q) * 16'(blu_q));

	assign dx_abs = dx_q[D_W-1] ? D_W'(-dx_q) : D_W'(dx_q);
	assign dy_abs = dy_q[D_W-1] ? D_W'(-dy_q) : D_W'(dy_q);
	assign dxm    = dx_abs[MAG_W-1:0];
	assign dym    = dy_abs[MAG_W-1:0];
	assign dx_sq  = SQ_W'(dxm) * SQ_W'(dxm);
	assign dy_sq  = SQ_W'(dym) * SQ_W'(dym);

	assign sqrt_start = (state_q == ST_HSQ) || (state_q == ST_SQY);
	assign sqrt_rad   = (state_q == ST_HSQ) ? (RAD_W'(rgb_sq) << 30)
		: RAD_W'(sum_q + dy_sq + SQ_W'(DZ_Q15) * SQ_W'(DZ_Q15));

	snm_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (sqrt_rad),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// Height = root / 255 by reciprocal multiply and shift.
	assign h_prod = HGT_PROD_W'(sqrt_root) * HGT_PROD_W'(HGT_RECIP);

	// Component under division: dx, dy, then the fixed dz.
	always_comb begin
		case (ci_q)
			2'd0:    begin cmag = dxm; cneg = dx_q[D_W-1]; end
			2'd1:    begin cmag = dym; cneg = dy_q[D_W-1]; end
			default: begin cmag = DZ_Q15; cneg = 1'b0; end
		endcase
	end

	assign div_start = (state_q == ST_CST);
	assign div_num   = {cmag, 15'd0};
	assign div_den   = DEN_W'(len_q);

	snm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign cbyte = to_byte(cneg, div_quo);

	// Sequencer: one request at a time, reads and writes through the single RAM port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rk_q       <= '0;
			ci_q       <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_RD);
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= (s_tuser == FUNC_QUERY) ? ST_NB : ST_HSQ;
					end
				end
				ST_HSQ:   state_q <= ST_HSQRT;
				ST_HSQRT: begin
					if (sqrt_done) begin
						state_q <= ST_HWR;
					end
				end
				ST_HWR:   state_q <= ST_IDLE;
				ST_NB: begin
					rk_q    <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					rk_q <= rk_q + 1'b1;
					if (rk_q == NB_L) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC:   state_q <= ST_SQX;
				ST_SQX:   state_q <= ST_SQY;
				ST_SQY:   state_q <= ST_LSQRT;
				ST_LSQRT: begin
					if (sqrt_done) begin
						ci_q    <= '0;
						state_q <= ST_CST;
					end
				end
				ST_CST:   state_q <= ST_CDIV;
				ST_CDIV: begin
					if (div_done) begin
						ci_q    <= ci_q + 1'b1;
						state_q <= (ci_q == 2'd2) ? ST_OUT : ST_CST;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		rd_k_s1 <= rk_q;
		if (in_acc) begin
			func_q <= s_tuser;
			col_q  <= s_tdata[9:0];
			row_q  <= s_tdata[19:10];
			red_q  <= s_tdata[27:20];
			grn_q  <= s_tdata[35:28];
			blu_q  <= s_tdata[43:36];
		end
		if (state_q == ST_HSQ) begin
			wr_ok_q   <= (xc < XW'(MAX_WIDTH)) && (yc < YW'(MAX_HEIGHT));
			wr_addr_q <= AW'(yc) * AW'(MAX_WIDTH) + AW'(xc);
		end
		if (state_q == ST_HSQRT && sqrt_done) begin
			h_q <= h_prod[HGT_RCP_SH +: HGT_W];
		end
		if (state_q == ST_NB) begin
			xm_q <= (xc == '0) ? (wsz_q - 1'b1) : (((xc - 1'b1) >= wsz_q) ? '0 : (xc - 1'b1));
			x0_q <= (xc >= wsz_q) ? '0 : xc;
			xp_q <= ((xc + 1'b1) >= wsz_q) ? '0 : (xc + 1'b1);
			ym_q <= (yc == '0) ? (hsz_q - 1'b1) : (((yc - 1'b1) >= hsz_q) ? '0 : (yc - 1'b1));
			y0_q <= (yc >= hsz_q) ? '0 : yc;
			yp_q <= ((yc + 1'b1) >= hsz_q) ? '0 : (yc + 1'b1);
			dx_q <= '0;
			dy_q <= '0;
		end else if (rd_vld_s1) begin
			dx_q <= dx_q + scale(ram_rdata, weight_x(rd_k_s1));
			dy_q <= dy_q + scale(ram_rdata, weight_y(rd_k_s1));
		end
		if (state_q == ST_SQX) begin
			sum_q <= dx_sq;
		end
		if (state_q == ST_LSQRT && sqrt_done) begin
			len_q <= sqrt_root;
		end
		if (state_q == ST_CDIV && div_done) begin
			if (ci_q == 2'd0) begin
				bx_q <= cbyte;
			end else if (ci_q == 2'd1) begin
				by_q <= cbyte;
			end
		end
		if (out_load) begin
			m_tdata_q <= {bz_q, by_q, bx_q};
		end
	end

	// The z byte is produced last.
	always_ff @(posedge clk) begin
		if (state_q == ST_CDIV && div_done && ci_q == 2'd2) begin
			bz_q <= cbyte;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Input taken only while the sequencer is free.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE)
		else $error("request taken while busy");

	// A write request must not reach the RAM write slot as a query.
	a_write_func: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> func_q == FUNC_WRITE)
		else $error("store written by a query");

	// Neighbour data only returns in the read and accumulate states.
	a_rd_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_RD || state_q == ST_ACC))
		else $error("stray neighbour read");

	// A loaded result is shown on the next cycle.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("result lost on load");

endmodule

// File: tb/sobel_normal_map_tb.sv
// Testbench for sobel_normal_map: height writes, Sobel normal queries, wrap configuration.
module sobel_normal_map_tb
	import snm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXW = 1024;
	localparam int MAXH = 1024;
	localparam int WRITE_DRAIN = 120;    // a write yields no result; let it finish
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic       func;
		logic [9:0] col;
		logic [9:0] row;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_req_t;

	typedef struct packed {
		logic [7:0] nx;
		logic [7:0] ny;
		logic [7:0] nz;
	} normal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	sobel_normal_map DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor state: heights, written flags, image size in use.
	logic [15:0] heights [int];
	int          img_w = 1024;
	int          img_h = 1024;

	pixel_req_t pending_reqs [$];
	normal_t    normals_due [$];
	int         fails = 0;
	longint     cycles = 0;

	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	function automatic int clamp_dim(input int v, input int mx);
		v &= 'h7FF;
		if (v == 0) return 1;
		if (v > mx) return mx;
		return v;
	endfunction

	function automatic int wrapc(input int c, input int sz);
		if (c < 0) return sz - 1;
		if (c >= sz) return 0;
		return c;
	endfunction

	function automatic longint height_at(input int c, input int r);
		int x, y;
		x = wrapc(c, img_w);
		y = wrapc(r, img_h);
		if (!heights.exists(y * MAXW + x)) return 0;
		return heights[y * MAXW + x];
	endfunction

	function automatic logic [7:0] component_byte(input longint d, input longint unsigned len);
		longint unsigned mag, q;
		longint n;
		mag = d < 0 ? -d : d;
		q = (mag << 15) / len;
		if (q > 32768) q = 32768;
		n = d < 0 ? -longint'(q) : longint'(q);
		return 8'(((n + 32768) * 255) >> 16);
	endfunction

	// Apply one accepted request to the predictor; queue a normal for queries.
	task automatic predict_normal(input pixel_req_t p);
		longint tl, t, tr, rr, br, b, bl, l, dx, dy;
		longint unsigned s, len;
		normal_t n;
		if (p.func == FUNC_WRITE) begin
			s = p.red * p.red + p.green * p.green + p.blue * p.blue;
			heights[p.row * MAXW + p.col] = 16'(root64(s << 30) / 255);
			return;
		end
		tl = height_at(p.col - 1, p.row - 1);
		t  = height_at(p.col - 1, p.row);
		tr = height_at(p.col - 1, p.row + 1);
		rr = height_at(p.col, p.row + 1);
		br = height_at(p.col + 1, p.row + 1);
		b  = height_at(p.col + 1, p.row);
		bl = height_at(p.col + 1, p.row - 1);
		l  = height_at(p.col, p.row - 1);
		dx = (tr + 2 * rr + br) - (tl + 2 * l + bl);
		dy = (bl + 2 * b + br) - (tl + 2 * t + tr);
		len = root64(dx * dx + dy * dy + 10813 * 10813);
		n.nx = component_byte(dx, len);
		n.ny = component_byte(dy, len);
		n.nz = component_byte(10813, len);
		normals_due.push_back(n);
	endtask

	// Request driver: random gap before each request, hold until accepted.
	int send_gap = 0;
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			predict_normal(pixel_req_t'({s_tuser, s_tdata[9:0], s_tdata[19:10],
				s_tdata[27:20], s_tdata[35:28], s_tdata[43:36]}));
			void'(pending_reqs.pop_front());
			send_gap = $urandom_range(0, 13);
			if ($urandom_range(0, 3) == 0) send_gap = 0;
		end
		if (!(s_tvalid && !s_tready)) begin
			if (send_gap > 0 || pending_reqs.size() == 0 || (s_tvalid && s_tready
					&& pending_reqs.size() == 0)) begin
				s_tvalid <= 1'b0;
				if (send_gap > 0) send_gap--;
			end else begin
				s_tvalid <= 1'b1;
				s_tuser <= pending_reqs[0].func;
				s_tdata <= {4'b0, pending_reqs[0].blue, pending_reqs[0].green,
					pending_reqs[0].red, pending_reqs[0].row, pending_reqs[0].col};
			end
		end
	end

	// Result monitor with its own random stall per result.
	int recv_gap = 0;
	always @(posedge clk) begin
		normal_t got, want;
		cycles++;
		if (m_tvalid && m_tready) begin
			got = m_tdata[23:0];
			got = '{nx: m_tdata[7:0], ny: m_tdata[15:8], nz: m_tdata[23:16]};
			if (normals_due.size() == 0) begin
				$display("%0t unexpected normal %h", $realtime, m_tdata);
				fails++;
			end else begin
				want = normals_due.pop_front();
				if (got.nx !== want.nx)
					$display("%0t normal_x expected %0d actual %0d", $realtime, want.nx, got.nx);
				if (got.ny !== want.ny)
					$display("%0t normal_y expected %0d actual %0d", $realtime, want.ny, got.ny);
				if (got.nz !== want.nz)
					$display("%0t normal_z expected %0d actual %0d", $realtime, want.nz, got.nz);
				if (got !== want) fails++;
			end
			recv_gap = $urandom_range(0, 13);
			if ($urandom_range(0, 3) == 0) recv_gap = 0;
		end
		if (recv_gap > 0) begin
			m_tready <= 1'b0;
			recv_gap--;
		end else begin
			m_tready <= 1'b1;
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DAT_W'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_WIDTH) img_w = clamp_dim(val, MAXW);
		else if (idx == CFG_HEIGHT) img_h = clamp_dim(val, MAXH);
	endtask

	// Wait for the block to drain every queued request and expected normal.
	task automatic drain();
		while (pending_reqs.size() != 0 || s_tvalid || normals_due.size() != 0)
			@(posedge clk);
		repeat (WRITE_DRAIN) @(posedge clk);
	endtask

	function automatic pixel_req_t pixel_write(input int c, input int r);
		pixel_req_t p;
		p.func = FUNC_WRITE;
		p.col = 10'(c);
		p.row = 10'(r);
		p.red = 8'($urandom);
		p.green = 8'($urandom);
		p.blue = 8'($urandom);
		if ($urandom_range(0, 9) == 0) {p.red, p.green, p.blue} = '1;
		if ($urandom_range(0, 9) == 0) {p.red, p.green, p.blue} = '0;
		return p;
	endfunction

	function automatic pixel_req_t pixel_query(input int c, input int r);
		pixel_req_t p;
		p = '0;
		p.func = FUNC_QUERY;
		p.col = 10'(c);
		p.row = 10'(r);
		{p.red, p.green, p.blue} = 24'($urandom);    // ignored fields toggle anyway
		return p;
	endfunction

	// Fill a whole w x h image, so every wrapped neighbour has been written.
	task automatic fill_image(input int w, input int h, input int flat);
		pixel_req_t p;
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++) begin
				p = pixel_write(c, r);
				if (flat != 0) {p.red, p.green, p.blue} = {3{8'(flat)}};
				pending_reqs.push_back(p);
			end
	endtask

	initial begin
		int w, h;
		pixel_req_t p;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: smallest image, full-scale heights, corners.
		write_reg(CFG_WIDTH, 0);
		write_reg(CFG_HEIGHT, 0);
		fill_image(1, 1, 255);
		pending_reqs.push_back(pixel_query(0, 0));
		pending_reqs.push_back(pixel_query(1023, 1023));   // outside image, wraps inside
		drain();
		write_reg(CFG_WIDTH, 3);
		write_reg(CFG_HEIGHT, 3);
		fill_image(3, 3, 0);
		p = pixel_write(1, 1);
		{p.red, p.green, p.blue} = '1;
		pending_reqs.push_back(p);
		pending_reqs.push_back(pixel_query(0, 0));
		pending_reqs.push_back(pixel_query(2, 2));
		pending_reqs.push_back(pixel_query(1, 0));
		pending_reqs.push_back(pixel_query(0, 1));
		// writes at two far corners of the store, both outside the image
		pending_reqs.push_back(pixel_write(1023, 1023));
		pending_reqs.push_back(pixel_write(1023, 0));
		drain();

		// Register values at and above the maximum: clamped at the store size, query two opposite corners.
		write_reg(CFG_WIDTH, 2047);
		write_reg(CFG_HEIGHT, 1024);
		for (int r = 1022; r <= 1023; r++)
			for (int c = 1022; c <= 1023; c++) pending_reqs.push_back(pixel_write(c, r));
		for (int r = 0; r <= 1; r++)
			for (int c = 1022; c <= 1023; c++) pending_reqs.push_back(pixel_write(c, r));
		for (int r = 1022; r <= 1023; r++)
			for (int c = 0; c <= 1; c++) pending_reqs.push_back(pixel_write(c, r));
		for (int r = 0; r <= 1; r++)
			for (int c = 0; c <= 1; c++) pending_reqs.push_back(pixel_write(c, r));
		pending_reqs.push_back(pixel_query(1023, 1023));
		pending_reqs.push_back(pixel_query(0, 0));
		drain();

		// Random phases: small images filled then queried with fresh writes mixed in.
		for (int ph = 0; ph < 20; ph++) begin
			w = $urandom_range(1, 9);
			h = $urandom_range(1, 9);
			write_reg(CFG_WIDTH, w);
			write_reg(CFG_HEIGHT, h);
			fill_image(w, h, 0);
			for (int i = 0; i < 30; i++) begin
				if ($urandom_range(0, 2) == 0)
					pending_reqs.push_back(pixel_write($urandom_range(0, w - 1),
						$urandom_range(0, h - 1)));
				else if ($urandom_range(0, 9) == 0)   // store-wide writes, mostly outside the image
					pending_reqs.push_back(pixel_write($urandom_range(0, 1023),
						$urandom_range(0, 1023)));
				else if ($urandom_range(0, 5) == 0)   // store-wide position; outside the image it wraps inside
					pending_reqs.push_back(pixel_query($urandom_range(0, 1023),
						$urandom_range(0, 1023)));
				else
					pending_reqs.push_back(pixel_query($urandom_range(0, w - 1),
						$urandom_range(0, h - 1)));
			end
			drain();
		end
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: files.f
src/snm_pkg.sv
src/snm_ram.sv
src/snm_sqrt.sv
src/snm_div.sv
src/sobel_normal_map.sv
tb/sobel_normal_map_tb.sv
